>>> rtl/blm_pkg.sv
// ----------------------------------------------------------------------------
// blm_pkg
// shared constants, state codes and control structs for the bounded level
// multiset core
// ----------------------------------------------------------------------------
package blm_pkg;

   // store geometry
   localparam int CAPACITY   = 256;
   localparam int LEVEL_BITS = 9;
   localparam int ADDR_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);

   // configuration port
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 9;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_LEVEL = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_LEVEL = 1'd1;

   localparam logic [CSR_DATA_BITS-1:0] MIN_LEVEL_RESET = 9'd30;
   localparam logic [CSR_DATA_BITS-1:0] MAX_LEVEL_RESET = 9'd400;

   // item opcodes
   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // sequencer states, one-hot
   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_ADD     = 6'b000010,
      S_SCAN    = 6'b000100,
      S_MOVE_RD = 6'b001000,
      S_MOVE_WR = 6'b010000,
      S_DONE    = 6'b100000
   } state_type;

   // control to the min/max unit
   typedef struct packed {
      logic                  clear;
      logic                  accumulate;
      logic [LEVEL_BITS-1:0] value;
   } scan_ctl_type;

   // running min/max held by the unit
   typedef struct packed {
      logic                  seen;
      logic [LEVEL_BITS-1:0] lowest;
      logic [LEVEL_BITS-1:0] highest;
   } scan_stat_type;

endpackage

>>> rtl/blm_if.sv
// ----------------------------------------------------------------------------
// blm_if
// valid/ready channels for request and response words
// ----------------------------------------------------------------------------
interface blm_req_if;
   logic                            valid;
   logic                            ready;
   logic                            opcode;
   logic [blm_pkg::LEVEL_BITS-1:0]  level;

   modport source (output valid, output opcode, output level, input ready);
   modport sink   (input valid, input opcode, input level, output ready);
endinterface

interface blm_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            success;
   logic [blm_pkg::COUNT_BITS-1:0]  item_count;
   logic                            is_empty;
   logic [blm_pkg::LEVEL_BITS-1:0]  lowest_level;
   logic [blm_pkg::LEVEL_BITS-1:0]  highest_level;

   modport source (output valid, output success, output item_count, output is_empty,
                   output lowest_level, output highest_level, input ready);
   modport sink   (input valid, input success, input item_count, input is_empty,
                   input lowest_level, input highest_level, output ready);
endinterface

>>> rtl/blm_store.sv
// ----------------------------------------------------------------------------
// blm_store
// level storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module blm_store (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [blm_pkg::ADDR_BITS-1:0]   wr_addr,
   input  logic [blm_pkg::LEVEL_BITS-1:0]  wr_data,
   input  logic                            rd_en,
   input  logic [blm_pkg::ADDR_BITS-1:0]   rd_addr,
   output logic [blm_pkg::LEVEL_BITS-1:0]  rd_data
);

   logic [blm_pkg::LEVEL_BITS-1:0] mem [blm_pkg::CAPACITY];
   logic [blm_pkg::LEVEL_BITS-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/blm_minmax.sv
// ----------------------------------------------------------------------------
// blm_minmax
// shared compare unit: folds one level a cycle into the running min and max
// ----------------------------------------------------------------------------
module blm_minmax (
   input  logic                    clock,
   input  logic                    reset,
   input  blm_pkg::scan_ctl_type   ctl,
   output blm_pkg::scan_stat_type  stat
);

   logic                           seen_ff, seen_in;
   logic [blm_pkg::LEVEL_BITS-1:0] lowest_ff, lowest_in;
   logic [blm_pkg::LEVEL_BITS-1:0] highest_ff, highest_in;

   // compare and select
   always_comb begin
      seen_in    = seen_ff;
      lowest_in  = lowest_ff;
      highest_in = highest_ff;
      if (ctl.clear) begin
         seen_in = 1'b0;
      end else if (ctl.accumulate) begin
         seen_in = 1'b1;
         if (!seen_ff || (ctl.value < lowest_ff)) begin
            lowest_in = ctl.value;
         end
         if (!seen_ff || (ctl.value > highest_ff)) begin
            highest_in = ctl.value;
         end
      end
   end

   // control flag
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   // extremes
   always_ff @(posedge clock) begin
      lowest_ff  <= lowest_in;
      highest_ff <= highest_in;
   end

   // zero when nothing is held
   assign stat.seen    = seen_ff;
   assign stat.lowest  = seen_ff ? lowest_ff  : '0;
   assign stat.highest = seen_ff ? highest_ff : '0;

endmodule

>>> rtl/bounded_level_multiset_core.sv
// An add passes through the add state and then the done state, where the response
// register loads; a remove scans the store through its single read port, one entry a
// cycle, then, when the level is found, moves the last entry into its hole.
// Throughput: one word at a time; the next request is taken the cycle after the
// response register loads; the done state waits while the response channel stalls.
// Reset: synchronous, active high; count and min/max clear, limits 30 and 400.
// ----------------------------------------------------------------------------
// bounded_level_multiset_core
// bounded multiset of levels with count, min and max reported per word
// ----------------------------------------------------------------------------
module bounded_level_multiset_core (
   input  logic                               clock,
   input  logic                               reset,
   blm_req_if.sink                            req_if,
   blm_rsp_if.source                          rsp_if,
   input  logic                               csr_we,
   input  logic [blm_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [blm_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int LB = blm_pkg::LEVEL_BITS;
   localparam int AB = blm_pkg::ADDR_BITS;
   localparam int CB = blm_pkg::COUNT_BITS;

   blm_pkg::state_type      state_ff, state_in;
   logic [LB-1:0]           min_level_ff, max_level_ff;
   logic [CB-1:0]           count_ff, count_in;
   logic                    op_ff;
   logic [LB-1:0]           level_ff;
   logic [CB-1:0]           ptr_ff, ptr_in;
   logic                    dvld_ff;
   logic [AB-1:0]           didx_ff;
   logic                    found_ff, found_in;
   logic [AB-1:0]           pos_ff, pos_in;
   logic                    ok_ff, ok_in;

   logic                    rsp_valid_ff;
   logic                    rsp_success_ff;
   logic [CB-1:0]           rsp_count_ff;
   logic                    rsp_empty_ff;
   logic [LB-1:0]           rsp_lowest_ff;
   logic [LB-1:0]           rsp_highest_ff;

   logic                    mem_we, mem_re;
   logic [AB-1:0]           mem_waddr, mem_raddr;
   logic [LB-1:0]           mem_wdata, mem_rdata;
   logic [CB-1:0]           last_idx;
   logic                    scan_issue, rsp_free, add_ok;

   blm_pkg::scan_ctl_type   mm_ctl;
   blm_pkg::scan_stat_type  mm_stat;

   blm_store u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   blm_minmax u_minmax (
      .clock (clock),
      .reset (reset),
      .ctl   (mm_ctl),
      .stat  (mm_stat)
   );

   assign req_if.ready = (state_ff == blm_pkg::S_IDLE);
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;
   assign scan_issue   = (state_ff == blm_pkg::S_SCAN) && (ptr_ff < count_ff);
   assign last_idx     = count_ff - CB'(1);
   assign add_ok       = (level_ff >= min_level_ff) && (level_ff <= max_level_ff) &&
                         (count_ff < CB'(blm_pkg::CAPACITY));

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      found_in     = found_ff;
      pos_in       = pos_ff;
      ok_in        = ok_ff;
      mem_we       = 1'b0;
      mem_waddr    = count_ff[AB-1:0];
      mem_wdata    = level_ff;
      mem_re       = 1'b0;
      mem_raddr    = ptr_ff[AB-1:0];
      mm_ctl.clear      = 1'b0;
      mm_ctl.accumulate = 1'b0;
      mm_ctl.value      = level_ff;
      case (state_ff)
         blm_pkg::S_IDLE: begin
            if (req_if.valid) begin
               ptr_in   = '0;
               found_in = 1'b0;
               if (req_if.opcode == blm_pkg::OP_ADD) begin
                  state_in = blm_pkg::S_ADD;
               end else begin
                  mm_ctl.clear = 1'b1;
                  state_in     = blm_pkg::S_SCAN;
               end
            end
         end
         blm_pkg::S_ADD: begin
            ok_in = add_ok;
            if (add_ok) begin
               mem_we            = 1'b1;
               count_in          = count_ff + CB'(1);
               mm_ctl.accumulate = 1'b1;
            end
            state_in = blm_pkg::S_DONE;
         end
         blm_pkg::S_SCAN: begin
            // issue the next read
            if (scan_issue) begin
               mem_re = 1'b1;
               ptr_in = ptr_ff + CB'(1);
            end
            // first match is dropped, every other entry feeds min/max
            if (dvld_ff) begin
               mm_ctl.value = mem_rdata;
               if ((mem_rdata == level_ff) && !found_ff) begin
                  found_in = 1'b1;
                  pos_in   = didx_ff;
               end else begin
                  mm_ctl.accumulate = 1'b1;
               end
            end
            if (!scan_issue && !dvld_ff) begin
               ok_in    = found_ff;
               state_in = found_ff ? blm_pkg::S_MOVE_RD : blm_pkg::S_DONE;
            end
         end
         blm_pkg::S_MOVE_RD: begin
            mem_re    = 1'b1;
            mem_raddr = last_idx[AB-1:0];
            state_in  = blm_pkg::S_MOVE_WR;
         end
         blm_pkg::S_MOVE_WR: begin
            // last entry fills the hole
            mem_we    = 1'b1;
            mem_waddr = pos_ff;
            mem_wdata = mem_rdata;
            count_in  = last_idx;
            state_in  = blm_pkg::S_DONE;
         end
         blm_pkg::S_DONE: begin
            if (rsp_free) begin
               state_in = blm_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = blm_pkg::S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= blm_pkg::S_IDLE;
         count_ff <= '0;
         dvld_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         dvld_ff  <= scan_issue;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         op_ff    <= req_if.opcode;
         level_ff <= req_if.level;
      end
      ptr_ff   <= ptr_in;
      didx_ff  <= ptr_ff[AB-1:0];
      found_ff <= found_in;
      pos_ff   <= pos_in;
      ok_ff    <= ok_in;
   end

   // limit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_level_ff <= blm_pkg::MIN_LEVEL_RESET;
         max_level_ff <= blm_pkg::MAX_LEVEL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            blm_pkg::CSR_MIN_LEVEL: min_level_ff <= csr_wdata[LB-1:0];
            blm_pkg::CSR_MAX_LEVEL: max_level_ff <= csr_wdata[LB-1:0];
            default: ;
         endcase
      end
   end

   // response word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == blm_pkg::S_DONE) && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == blm_pkg::S_DONE) && rsp_free) begin
         rsp_success_ff <= ok_ff;
         rsp_count_ff   <= count_ff;
         rsp_empty_ff   <= (count_ff == '0);
         rsp_lowest_ff  <= mm_stat.lowest;
         rsp_highest_ff <= mm_stat.highest;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.success       = rsp_success_ff;
   assign rsp_if.item_count    = rsp_count_ff;
   assign rsp_if.is_empty      = rsp_empty_ff;
   assign rsp_if.lowest_level  = rsp_lowest_ff;
   assign rsp_if.highest_level = rsp_highest_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(blm_pkg::CAPACITY))
      else $error("stored count beyond capacity");

   a_seen_matches_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == blm_pkg::S_IDLE) |-> (mm_stat.seen == (count_ff != '0)))
      else $error("min/max view out of step with count");

   a_order: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == blm_pkg::S_IDLE) && mm_stat.seen) |->
         (mm_stat.lowest <= mm_stat.highest))
      else $error("lowest above highest");

   a_add_op: assert property (@(posedge clock) disable iff (reset)
      (state_ff == blm_pkg::S_ADD) |-> (op_ff == blm_pkg::OP_ADD))
      else $error("add path taken for a remove word");

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the bounded level multiset core: a shadow store
// predicts success, count, empty flag and min/max for every request word;
// stimulus runs through directed corners, a fill to capacity and random
// traffic under several level limits, with random idling on both channels
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LB = blm_pkg::LEVEL_BITS;
   localparam int CB = blm_pkg::COUNT_BITS;

   localparam int unsigned LIMIT_CYCLES  = 3000000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned DRAIN_CYCLES  = 270;
   localparam int unsigned HOLD_AT_WORD  = 1000;
   localparam int unsigned HOLD_CYCLES   = 2500;

   // one response word as seen on the rsp channel
   typedef struct packed {
      logic          success;
      logic [CB-1:0] item_count;
      logic          is_empty;
      logic [LB-1:0] lowest_level;
      logic [LB-1:0] highest_level;
   } level_summary_type;

   // shadow multiset and queue of predicted response words
   class level_board_type;
      logic [LB-1:0]         levels [blm_pkg::CAPACITY];
      int unsigned           count;
      logic [LB-1:0]         low_limit;
      logic [LB-1:0]         high_limit;
      level_summary_type     pending [$];
      int unsigned           mismatches;

      function new();
         count      = 0;
         low_limit  = blm_pkg::MIN_LEVEL_RESET;
         high_limit = blm_pkg::MAX_LEVEL_RESET;
         mismatches = 0;
      endfunction

      function void set_limits(logic [LB-1:0] lo, logic [LB-1:0] hi);
         low_limit  = lo;
         high_limit = hi;
      endfunction

      // apply an accepted request word and queue the response it should give
      function void note_request(logic op, logic [LB-1:0] level);
         level_summary_type want;
         bit                done;
         want = '0;
         done = 0;
         if (op == blm_pkg::OP_ADD) begin
            if (level >= low_limit && level <= high_limit && count < blm_pkg::CAPACITY) begin
               levels[count] = level;
               count++;
               done = 1;
            end
         end else begin
            for (int unsigned i = 0; i < count && !done; i++) begin
               if (levels[i] == level) begin
                  // last entry fills the hole
                  levels[i] = levels[count-1];
                  count--;
                  done = 1;
               end
            end
         end
         want.success    = done;
         want.item_count = CB'(count);
         want.is_empty   = (count == 0);
         if (count > 0) begin
            want.lowest_level  = levels[0];
            want.highest_level = levels[0];
            for (int unsigned i = 1; i < count; i++) begin
               if (levels[i] < want.lowest_level) want.lowest_level = levels[i];
               if (levels[i] > want.highest_level) want.highest_level = levels[i];
            end
         end
         pending.push_back(want);
      endfunction

      function void compare_field(string name, logic [15:0] want_val, logic [15:0] got_val);
         if (got_val !== want_val) begin
            $display("%0t: %s differs, expected %0d actual %0d", $time, name, want_val,
                     got_val);
            mismatches++;
         end
      endfunction

      // compare a response word against the oldest prediction
      function void check_response(level_summary_type got);
         level_summary_type want;
         if (pending.size() == 0) begin
            $display("%0t: response word with nothing outstanding, actual %h", $time, got);
            mismatches++;
            return;
         end
         want = pending.pop_front();
         compare_field("success", 16'(want.success), 16'(got.success));
         compare_field("item_count", 16'(want.item_count), 16'(got.item_count));
         compare_field("is_empty", 16'(want.is_empty), 16'(got.is_empty));
         compare_field("lowest_level", 16'(want.lowest_level), 16'(got.lowest_level));
         compare_field("highest_level", 16'(want.highest_level), 16'(got.highest_level));
      endfunction
   endclass

   logic                              clock;
   logic                              reset;
   logic                              csr_we;
   logic [blm_pkg::CSR_IDX_BITS-1:0]  csr_index;
   logic [blm_pkg::CSR_DATA_BITS-1:0] csr_wdata;

   blm_req_if req_ch ();
   blm_rsp_if rsp_ch ();

   level_board_type     board;
   bit                  steady_flow;
   int unsigned         cycle_count;
   int unsigned         stall_left;
   int unsigned         stall_gap;
   int unsigned         words_taken;

   bounded_level_multiset_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // idle length: mostly none, some short, a few long
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (steady_flow) return 0;
      roll = $urandom_range(99);
      if (roll < 65) return 0;
      if (roll < 92) return $urandom_range(3, 1);
      if (roll < 98) return $urandom_range(12, 4);
      return $urandom_range(80, 20);
   endfunction

   // run-length guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // response side: check accepted words, stall at random, one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left  = 0;
         words_taken = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            board.check_response(level_summary_type'{rsp_ch.success, rsp_ch.item_count,
                                                     rsp_ch.is_empty, rsp_ch.lowest_level,
                                                     rsp_ch.highest_level});
            words_taken++;
            if (words_taken == HOLD_AT_WORD) stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            stall_gap = pick_gap();
            if (stall_gap == 0) begin
               rsp_ch.ready <= 1'b1;
            end else begin
               rsp_ch.ready <= 1'b0;
               stall_left = stall_gap - 1;
            end
         end
      end
   end

   // offer one request word, after a random gap, and wait for it to be taken
   task automatic send_word(logic op, logic [LB-1:0] level);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.opcode <= op;
      req_ch.level  <= level;
      do @(posedge clock); while (!req_ch.ready);
      board.note_request(op, level);
   endtask

   // stop offering and wait for every predicted word to come back
   task automatic wait_for_results(int unsigned extra);
      req_ch.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // write both limits while the core is idle
   task automatic change_limits(logic [LB-1:0] lo, logic [LB-1:0] hi);
      wait_for_results(SETTLE_CYCLES);
      csr_we    <= 1'b1;
      csr_index <= blm_pkg::CSR_MIN_LEVEL;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= blm_pkg::CSR_MAX_LEVEL;
      csr_wdata <= hi;
      @(posedge clock);
      csr_we <= 1'b0;
      board.set_limits(lo, hi);
   endtask

   // random traffic, steered to keep the store partly filled
   task automatic run_random(int unsigned items);
      logic          op;
      logic [LB-1:0] level;
      int unsigned   roll;
      for (int unsigned n = 0; n < items; n++) begin
         roll = $urandom_range(99);
         if (board.count < 8) op = (roll < 80) ? blm_pkg::OP_ADD : blm_pkg::OP_REMOVE;
         else if (board.count > 60) op = (roll < 30) ? blm_pkg::OP_ADD : blm_pkg::OP_REMOVE;
         else op = (roll < 50) ? blm_pkg::OP_ADD : blm_pkg::OP_REMOVE;
         if (op == blm_pkg::OP_ADD) begin
            if (board.low_limit <= board.high_limit && $urandom_range(99) < 80)
               level = LB'($urandom_range(board.high_limit, board.low_limit));
            else
               level = LB'($urandom_range(511));
         end else begin
            if (board.count > 0 && $urandom_range(99) < 80)
               level = board.levels[$urandom_range(board.count - 1)];
            else
               level = LB'($urandom_range(511));
         end
         send_word(op, level);
      end
   endtask

   initial begin
      board       = new();
      steady_flow = 0;
      cycle_count = 0;
      clock       = 1'b0;
      reset       = 1'b1;
      csr_we      = 1'b0;
      csr_index   = blm_pkg::CSR_MIN_LEVEL;
      csr_wdata   = '0;
      req_ch.valid  = 1'b0;
      req_ch.opcode = blm_pkg::OP_ADD;
      req_ch.level  = '0;
      rsp_ch.ready  = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset limits: empty store, range edges, duplicates, absent levels
      send_word(blm_pkg::OP_REMOVE, 9'd30);
      send_word(blm_pkg::OP_ADD, 9'd29);
      send_word(blm_pkg::OP_ADD, 9'd30);
      send_word(blm_pkg::OP_ADD, 9'd401);
      send_word(blm_pkg::OP_ADD, 9'd400);
      send_word(blm_pkg::OP_ADD, 9'd0);
      send_word(blm_pkg::OP_ADD, 9'd511);
      send_word(blm_pkg::OP_ADD, 9'd30);
      send_word(blm_pkg::OP_ADD, 9'd200);
      send_word(blm_pkg::OP_REMOVE, 9'd30);
      send_word(blm_pkg::OP_REMOVE, 9'd30);
      send_word(blm_pkg::OP_REMOVE, 9'd30);
      send_word(blm_pkg::OP_REMOVE, 9'd511);
      send_word(blm_pkg::OP_REMOVE, 9'd0);
      send_word(blm_pkg::OP_REMOVE, 9'd400);
      send_word(blm_pkg::OP_REMOVE, 9'd200);

      // widest range: both extreme levels accepted
      change_limits(9'd0, 9'd511);
      send_word(blm_pkg::OP_ADD, 9'd0);
      send_word(blm_pkg::OP_ADD, 9'd511);
      send_word(blm_pkg::OP_ADD, 9'd0);
      send_word(blm_pkg::OP_REMOVE, 9'd511);
      send_word(blm_pkg::OP_REMOVE, 9'd0);
      send_word(blm_pkg::OP_REMOVE, 9'd0);

      // inverted range: no add can succeed
      change_limits(9'd511, 9'd0);
      send_word(blm_pkg::OP_ADD, 9'd0);
      send_word(blm_pkg::OP_ADD, 9'd511);
      send_word(blm_pkg::OP_ADD, 9'd256);

      // single-level range
      change_limits(9'd100, 9'd100);
      send_word(blm_pkg::OP_ADD, 9'd99);
      send_word(blm_pkg::OP_ADD, 9'd101);
      send_word(blm_pkg::OP_ADD, 9'd100);
      send_word(blm_pkg::OP_REMOVE, 9'd100);

      // fill to capacity, push against the full store, then drain most of it
      change_limits(9'd0, 9'd511);
      while (board.count < blm_pkg::CAPACITY)
         send_word(blm_pkg::OP_ADD, LB'($urandom_range(511)));
      send_word(blm_pkg::OP_ADD, 9'd5);
      send_word(blm_pkg::OP_ADD, 9'd511);
      send_word(blm_pkg::OP_REMOVE, board.levels[$urandom_range(blm_pkg::CAPACITY - 1)]);
      send_word(blm_pkg::OP_ADD, 9'd77);
      while (board.count > 20)
         send_word(blm_pkg::OP_REMOVE, board.levels[$urandom_range(board.count - 1)]);

      // random traffic under several limit settings
      change_limits(blm_pkg::MIN_LEVEL_RESET, blm_pkg::MAX_LEVEL_RESET);
      run_random(150);
      wait_for_results(0);
      run_random(150);

      change_limits(9'd0, 9'd511);
      steady_flow = 1;
      run_random(100);
      steady_flow = 0;
      run_random(250);

      change_limits(LB'($urandom_range(250)), LB'($urandom_range(511, 260)));
      run_random(300);

      change_limits(LB'($urandom_range(511, 300)), LB'($urandom_range(200)));
      run_random(200);

      change_limits(9'd0, 9'd511);
      run_random(225);

      // let the last words come back, then a quiet spell
      wait_for_results(DRAIN_CYCLES);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
